@@ design/txprb_pkg.sv @@
package txprb_pkg;

  // Operation codes carried in the low bits of s_tdata
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PING  = 2'd1,
    OP_VOLT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RSSI_THR   = 3'd0,
    REG_VOLT_THR   = 3'd1,
    REG_PING_TMO   = 3'd2,
    REG_PROBE_PER  = 3'd3,
    REG_FIRST_CHK  = 3'd4,
    REG_ANSWER_TMO = 3'd5
  } reg_idx_t;

  // Controller modes, one-hot
  typedef enum logic [3:0] {
    MODE_OFF       = 4'b0001,
    MODE_OFF_PROBE = 4'b0010,
    MODE_ON        = 4'b0100,
    MODE_ON_PROBE  = 4'b1000
  } mode_t;

  // Reported state codes
  localparam logic [1:0] CODE_OFF       = 2'd0;
  localparam logic [1:0] CODE_OFF_PROBE = 2'd1;
  localparam logic [1:0] CODE_ON        = 2'd2;
  localparam logic [1:0] CODE_ON_PROBE  = 2'd3;

  // Field widths
  localparam int unsigned RSSI_W   = 8;
  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 8;
  localparam int unsigned RESULT_W = 4;

  // Reset values of the configuration registers
  localparam logic [RSSI_W-1:0] RST_RSSI_THR   = 8'd80;
  localparam logic [CFG_W-1:0]  RST_VOLT_THR   = 16'd1000;
  localparam logic [CFG_W-1:0]  RST_PING_TMO   = 16'd5000;
  localparam logic [CFG_W-1:0]  RST_PROBE_PER  = 16'd1000;
  localparam logic [CFG_W-1:0]  RST_FIRST_CHK  = 16'd200;
  localparam logic [CFG_W-1:0]  RST_ANSWER_TMO = 16'd500;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_OFF:       c = CODE_OFF;
      MODE_OFF_PROBE: c = CODE_OFF_PROBE;
      MODE_ON:        c = CODE_ON;
      MODE_ON_PROBE:  c = CODE_ON_PROBE;
      default:        c = CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

@@ design/wireless_power_tx_probe_fsm_unit.sv @@
// Transmitter probe controller: one item (tick, ping or voltage response) per clock
// while s_tready is high. An accepted item's result goes into the result register,
// or into the skid register while the output stalls; this two-entry output keeps
// s_tready high while one result waits downstream.
// Reset (rst, synchronous, active high): mode off, ages zero, transmitter off,
// output empty, configuration registers back to their defaults.
module wireless_power_tx_probe_fsm_unit #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata, lowest bit up: op[1:0], rssi[9:2], voltage_mv[25:10], zero fill
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [txprb_pkg::S_DATA_W-1:0]    s_tdata,
  // m_tdata, lowest bit up: tx_enable[0], probe_request[1], fsm_state_out[3:2], zero fill
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [txprb_pkg::M_DATA_W-1:0]    m_tdata,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [txprb_pkg::CFG_W-1:0]       cfg_data
);
  import txprb_pkg::*;

  // Compare width: wide enough for an age and for a 16-bit register
  localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  typedef logic [TIMER_WIDTH-1:0] age_t;
  typedef logic [CMP_W-1:0]       cmp_t;
  localparam age_t AGE_MAX = '1;

  // ---------------------------------------------------------------
  // Configuration registers; writes land at once, always ready.
  // ---------------------------------------------------------------
  logic [RSSI_W-1:0] rssi_limit;
  logic [CFG_W-1:0]  volt_limit;
  logic [CFG_W-1:0]  ping_timeout_ms;
  logic [CFG_W-1:0]  on_probe_period_ms;
  logic [CFG_W-1:0]  first_check_ms;
  logic [CFG_W-1:0]  probe_answer_timeout_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rssi_limit              <= RST_RSSI_THR;
      volt_limit              <= RST_VOLT_THR;
      ping_timeout_ms         <= RST_PING_TMO;
      on_probe_period_ms      <= RST_PROBE_PER;
      first_check_ms          <= RST_FIRST_CHK;
      probe_answer_timeout_ms <= RST_ANSWER_TMO;
    end else if (cfg_valid && cfg_ready) begin
      // indexes beyond the list are dropped
      case (reg_idx_t'(cfg_index))
        REG_RSSI_THR:   rssi_limit              <= cfg_data[RSSI_W-1:0];
        REG_VOLT_THR:   volt_limit              <= cfg_data;
        REG_PING_TMO:   ping_timeout_ms         <= cfg_data;
        REG_PROBE_PER:  on_probe_period_ms      <= cfg_data;
        REG_FIRST_CHK:  first_check_ms          <= cfg_data;
        REG_ANSWER_TMO: probe_answer_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input fields
  // ---------------------------------------------------------------
  op_t               in_op;
  logic [RSSI_W-1:0] in_rssi;
  logic [VOLT_W-1:0] in_volt;
  logic              accept;

  assign in_op   = op_t'(s_tdata[1:0]);
  assign in_rssi = s_tdata[9:2];
  assign in_volt = s_tdata[25:10];
  assign accept  = s_tvalid && s_tready;

  // ---------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------
  mode_t mode, mode_next;
  age_t  ping_age, ping_age_next;
  age_t  on_probe_age, on_probe_age_next;
  age_t  probe_wait_age, probe_wait_age_next;
  logic  tx_level, tx_level_next;
  logic  probe_req;

  // Saturated load for the first on-state probe: period - first_check,
  // zero when first_check exceeds the period, clipped to the age range.
  logic [CFG_W-1:0] load_diff;
  cmp_t             load_wide;
  age_t             load_age;

  always_comb begin
    load_diff = (first_check_ms > on_probe_period_ms) ? '0
              : (on_probe_period_ms - first_check_ms);
    load_wide = cmp_t'(load_diff);
    load_age  = (load_wide > cmp_t'(AGE_MAX)) ? AGE_MAX : age_t'(load_wide);
  end

  // Single-pass update; tick checks run in order on the running values.
  always_comb begin
    mode_next           = mode;
    ping_age_next       = ping_age;
    on_probe_age_next   = on_probe_age;
    probe_wait_age_next = probe_wait_age;
    tx_level_next       = tx_level;
    probe_req           = 1'b0;

    unique case (in_op)
      OP_TICK: begin
        ping_age_next       = (ping_age == AGE_MAX) ? AGE_MAX : ping_age + 1'b1;
        on_probe_age_next   = (on_probe_age == AGE_MAX) ? AGE_MAX : on_probe_age + 1'b1;
        probe_wait_age_next = (probe_wait_age == AGE_MAX) ? AGE_MAX
                            : probe_wait_age + 1'b1;
        // lost receiver
        if (mode_next != MODE_OFF &&
            cmp_t'(ping_age_next) >= cmp_t'(ping_timeout_ms)) begin
          tx_level_next = 1'b0;
          mode_next     = MODE_OFF;
        end
        // periodic on-state probe
        if (mode_next == MODE_ON &&
            cmp_t'(on_probe_age_next) >= cmp_t'(on_probe_period_ms)) begin
          probe_req           = 1'b1;
          probe_wait_age_next = '0;
          on_probe_age_next   = '0;
          mode_next           = MODE_ON_PROBE;
        end
        // unanswered probe
        if ((mode_next == MODE_OFF_PROBE || mode_next == MODE_ON_PROBE) &&
            cmp_t'(probe_wait_age_next) >= cmp_t'(probe_answer_timeout_ms)) begin
          tx_level_next = 1'b0;
          mode_next     = MODE_OFF;
        end
      end
      OP_PING: begin
        if (in_rssi < rssi_limit) begin
          ping_age_next = '0;
          if (mode == MODE_OFF) begin
            probe_req           = 1'b1;
            probe_wait_age_next = '0;
            mode_next           = MODE_OFF_PROBE;
          end
        end
      end
      OP_VOLT: begin
        if (mode == MODE_OFF_PROBE) begin
          if (in_volt > volt_limit) begin
            tx_level_next = 1'b0;
            mode_next     = MODE_OFF;
          end else begin
            tx_level_next     = 1'b1;
            on_probe_age_next = load_age;
            mode_next         = MODE_ON;
          end
        end else if (mode == MODE_ON_PROBE) begin
          if (in_volt > volt_limit) begin
            tx_level_next = 1'b1;
            mode_next     = MODE_ON;
          end else begin
            tx_level_next = 1'b0;
            mode_next     = MODE_OFF;
          end
        end
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_OFF;
      ping_age       <= '0;
      on_probe_age   <= '0;
      probe_wait_age <= '0;
      tx_level       <= 1'b0;
    end else if (accept) begin
      mode           <= mode_next;
      ping_age       <= ping_age_next;
      on_probe_age   <= on_probe_age_next;
      probe_wait_age <= probe_wait_age_next;
      tx_level       <= tx_level_next;
    end
  end

  // ---------------------------------------------------------------
  // Result register plus skid register
  // ---------------------------------------------------------------
  logic [RESULT_W-1:0] result_new;
  logic [RESULT_W-1:0] out_data;
  logic [RESULT_W-1:0] skid_data;
  logic                out_valid;
  logic                skid_valid;

  assign result_new = {mode_code(mode_next), probe_req, tx_level_next};
  assign s_tready   = !skid_valid;
  assign m_tvalid   = out_valid;
  assign m_tdata    = {{(M_DATA_W-RESULT_W){1'b0}}, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      // output slot frees up: drain skid first, else take the new item
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : result_new;
    end else if (accept) begin
      skid_data <= result_new;
    end
  end

endmodule

@@ design/txprb_checker.sv @@
module txprb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [txprb_pkg::M_DATA_W-1:0] m_tdata
);
  import txprb_pkg::*;

  // nothing left in the output after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // transmitter drives exactly in the on states
  a_tx_matches_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == m_tdata[3]))
    else $error("tx_enable disagrees with reported state");

  // a probe leaves the controller probing, or off after an instant answer timeout
  a_probe_not_on: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> (m_tdata[3:2] != CODE_ON))
    else $error("probe_request with the controller plainly on");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // m_tvalid is high on the next cycle after every accepted item
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted item left no result");

endmodule

bind wireless_power_tx_probe_fsm_unit txprb_checker u_txprb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import txprb_pkg::*;

  localparam int unsigned TW = 16;
  // cycles with no handshake on any channel before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 1000;
  // index with no register behind it; a write there must change nothing
  localparam logic [2:0] CFG_IDX_UNMAPPED = 3'd7;
  localparam int unsigned MAX_PRINTS = 40;

  // result item as it sits in m_tdata[3:0]
  typedef struct packed {
    logic [1:0] state;
    logic       probe_req;
    logic       tx_en;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  always #5 clk = ~clk;

  wireless_power_tx_probe_fsm_unit #(
    .TIMER_WIDTH(TW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Controller shadow: mode, ages and register copies, advanced once per
  // accepted item. Register copies follow the config channel handshakes.
  // ---------------------------------------------------------------------------
  logic [1:0]        ctl_mode   = CODE_OFF;
  logic              tx_on      = 1'b0;
  logic [TW-1:0]     age_ping   = '0;
  logic [TW-1:0]     age_period = '0;
  logic [TW-1:0]     age_answer = '0;

  logic [RSSI_W-1:0] thr_rssi   = RST_RSSI_THR;
  logic [CFG_W-1:0]  thr_volt   = RST_VOLT_THR;
  logic [CFG_W-1:0]  tmo_ping   = RST_PING_TMO;
  logic [CFG_W-1:0]  per_probe  = RST_PROBE_PER;
  logic [CFG_W-1:0]  chk_first  = RST_FIRST_CHK;
  logic [CFG_W-1:0]  tmo_answer = RST_ANSWER_TMO;

  status_t     expected_status[$];
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors  = 0;
  logic        no_idle   = 1'b0;

  function automatic logic [TW-1:0] age_step(logic [TW-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  function automatic status_t predict_status(op_t op, logic [RSSI_W-1:0] rssi,
                                             logic [VOLT_W-1:0] volt);
    status_t     r;
    logic        req;
    logic        above;
    logic [31:0] load;
    req = 1'b0;
    case (op)
      OP_TICK: begin
        age_ping   = age_step(age_ping);
        age_period = age_step(age_period);
        age_answer = age_step(age_answer);
        // checks run in this order, each on the mode left by the one before
        if (ctl_mode != CODE_OFF && age_ping >= tmo_ping) begin
          tx_on    = 1'b0;
          ctl_mode = CODE_OFF;
        end
        if (ctl_mode == CODE_ON && age_period >= per_probe) begin
          req        = 1'b1;
          age_answer = '0;
          age_period = '0;
          ctl_mode   = CODE_ON_PROBE;
        end
        if ((ctl_mode == CODE_OFF_PROBE || ctl_mode == CODE_ON_PROBE) &&
            age_answer >= tmo_answer) begin
          tx_on    = 1'b0;
          ctl_mode = CODE_OFF;
        end
      end
      OP_PING: begin
        if (rssi < thr_rssi) begin
          age_ping = '0;
          if (ctl_mode == CODE_OFF) begin
            req        = 1'b1;
            age_answer = '0;
            ctl_mode   = CODE_OFF_PROBE;
          end
        end
      end
      OP_VOLT: begin
        above = volt > thr_volt;
        if (ctl_mode == CODE_OFF_PROBE) begin
          if (above) begin
            tx_on    = 1'b0;
            ctl_mode = CODE_OFF;
          end else begin
            // first check later than the period: start from zero, full period
            load       = (chk_first > per_probe) ? 32'd0 : 32'(per_probe - chk_first);
            age_period = (load > {TW{1'b1}}) ? {TW{1'b1}} : load[TW-1:0];
            tx_on      = 1'b1;
            ctl_mode   = CODE_ON;
          end
        end else if (ctl_mode == CODE_ON_PROBE) begin
          tx_on    = above;
          ctl_mode = above ? CODE_ON : CODE_OFF;
        end
      end
      default: ;  // unused op: state shown as is, no probe
    endcase
    r.state     = ctl_mode;
    r.probe_req = req;
    r.tx_en     = tx_on;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (n_errors < MAX_PRINTS)
      $display("%0t ns MISMATCH %s", $time, what);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: results are checked before the same edge's input is predicted;
  // every result is registered, so the order never matters for correctness.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[RESULT_W-1:0];
        n_checked++;
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result %b with nothing expected", got));
        end else begin
          want = expected_status.pop_front();
          if (got.tx_en != want.tx_en)
            report_mismatch($sformatf("item %0d tx_enable %b, want %b",
                                      n_checked, got.tx_en, want.tx_en));
          if (got.probe_req != want.probe_req)
            report_mismatch($sformatf("item %0d probe_request %b, want %b",
                                      n_checked, got.probe_req, want.probe_req));
          if (got.state != want.state)
            report_mismatch($sformatf("item %0d fsm_state_out %0d, want %0d",
                                      n_checked, got.state, want.state));
        end
      end
      if (s_tvalid && s_tready)
        expected_status.push_back(predict_status(op_t'(s_tdata[1:0]), s_tdata[9:2],
                                                 s_tdata[25:10]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RSSI_THR:   thr_rssi   = cfg_data[RSSI_W-1:0];
          REG_VOLT_THR:   thr_volt   = cfg_data;
          REG_PING_TMO:   tmo_ping   = cfg_data;
          REG_PROBE_PER:  per_probe  = cfg_data;
          REG_FIRST_CHK:  chk_first  = cfg_data;
          REG_ANSWER_TMO: tmo_answer = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Downstream backpressure: random stalls, off in the final phase.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t ns watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input op_t op, input logic [RSSI_W-1:0] rssi,
                           input logic [VOLT_W-1:0] volt);
    logic [S_DATA_W-1:0] word;
    int unsigned         gap;
    word        = '0;
    word[1:0]   = op;
    word[9:2]   = rssi;
    word[25:10] = volt;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (n_checked < n_sent) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes never toggle it in one step.
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [RSSI_W-1:0] rssi_thr,
                            input logic [CFG_W-1:0] volt_thr, ping_tmo, probe_per,
                            first_chk, answer_tmo);
    wait_idle();
    write_reg(REG_RSSI_THR, CFG_W'(rssi_thr));
    write_reg(REG_VOLT_THR, volt_thr);
    write_reg(REG_PING_TMO, ping_tmo);
    write_reg(REG_PROBE_PER, probe_per);
    write_reg(REG_FIRST_CHK, first_chk);
    write_reg(REG_ANSWER_TMO, answer_tmo);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RSSI_W-1:0] rand_rssi();
    return RSSI_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VOLT_W-1:0] rand_volt();
    return VOLT_W'($urandom_range(0, 65535));
  endfunction

  // rssi that passes the current threshold, when one can
  function automatic logic [RSSI_W-1:0] pick_rssi_low();
    if (thr_rssi == 0)
      return rand_rssi();
    return RSSI_W'($urandom_range(0, thr_rssi - 1));
  endfunction

  // voltage at the threshold, one off either side, a range end, or random
  function automatic logic [VOLT_W-1:0] pick_voltage();
    case ($urandom_range(0, 5))
      0:       return thr_volt;
      1:       return thr_volt + 1'b1;
      2:       return thr_volt - 1'b1;
      3:       return '0;
      4:       return '1;
      default: return rand_volt();
    endcase
  endfunction

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(OP_TICK, rand_rssi(), rand_volt());
  endtask

  // One link session: accepted ping, answer, on-state time, probe answer.
  // A sprinkle of arbitrary items and random-rssi pings keeps it honest.
  task automatic send_session();
    if ($urandom_range(0, 5) == 0)
      send_item(op_t'($urandom_range(0, 3)), rand_rssi(), rand_volt());
    send_item(OP_PING, pick_rssi_low(), rand_volt());
    send_ticks($urandom_range(0, 6));
    send_item(OP_VOLT, rand_rssi(), pick_voltage());
    send_ticks(($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 20));
    send_item(OP_VOLT, rand_rssi(), pick_voltage());
    send_ticks($urandom_range(0, 10));
    if ($urandom_range(0, 3) == 0)
      send_item(OP_PING, rand_rssi(), rand_volt());
  endtask

  task automatic run_sessions(input int unsigned budget);
    int unsigned start;
    start = n_sent;
    while (n_sent - start < budget) send_session();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: rssi below 80 accepted, voltage above 1000 counts as above.
  task automatic test_directed_cases();
    send_item(OP_NOP, 8'hFF, 16'hFFFF);   // unused op, nothing moves
    send_item(OP_PING, 8'd255, 16'h0000); // rssi far too strong
    send_item(OP_PING, 8'd80, 16'h0000);  // rssi equal to threshold: rejected
    send_item(OP_VOLT, 8'h00, 16'd0);     // answer while off: ignored
    send_item(OP_PING, 8'd79, 16'h0000);  // accepted, probe from off
    send_item(OP_PING, 8'd0, 16'hFFFF);   // accepted again, no second probe
    send_item(OP_VOLT, 8'hAA, 16'd1001);  // above while off-probing: stay off
    send_item(OP_TICK, 8'h55, 16'h5555);
    send_item(OP_PING, 8'd0, 16'h0000);
    send_item(OP_VOLT, 8'h00, 16'd1000);  // equal counts as below: turn on
    send_item(OP_VOLT, 8'hFF, 16'd0);     // ignored while on
    send_item(OP_PING, 8'd0, 16'h0000);   // while on: only restarts ping age
    send_item(OP_NOP, 8'h00, 16'h0000);
    send_ticks(3);
    send_item(OP_VOLT, 8'h00, 16'hFFFF);  // still ignored while on
    send_item(OP_PING, 8'd255, 16'hFFFF);
  endtask

  task automatic test_short_timers();
    set_config(8'd128, 16'd2000, 16'd40, 16'd8, 16'd3, 16'd5);
    run_sessions(60);
  endtask

  // first check beyond the period: first on-state probe after a full period
  task automatic test_late_first_check();
    set_config(8'd255, 16'd30000, 16'd60, 16'd6, 16'hFFFF, 16'd12);
    run_sessions(30);
  endtask

  // zero timeouts fire on the first tick that looks at them; a zero answer
  // timeout ends an on-state probe in the very tick that sent it
  task automatic test_zero_timeouts();
    set_config(8'd200, 16'd500, 16'd0, 16'd0, 16'd0, 16'd0);
    run_sessions(30);
    set_config(8'd200, 16'd500, 16'd30, 16'd0, 16'd0, 16'd0);
    run_sessions(25);
  endtask

  task automatic test_threshold_extremes();
    // everything but rssi 255 accepted, any nonzero voltage is above
    set_config(8'd255, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    run_sessions(20);
    // all below: off answers turn on, on answers off; once on, probe each tick
    set_config(8'd255, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF);
    run_sessions(20);
    // no ping is ever accepted, so the controller stays off
    set_config(8'd0, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'd1);
    run_sessions(20);
    // unmapped index must leave every register alone
    wait_idle();
    write_reg(CFG_IDX_UNMAPPED, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_session();
  endtask

  task automatic set_random_config();
    set_config(rand_rssi(), rand_volt(), CFG_W'($urandom_range(5, 80)),
               CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(0, 25)),
               CFG_W'($urandom_range(1, 15)));
  endtask

  // random settings; the last stretch runs with no idling on either side
  task automatic test_random_settings();
    repeat (3) begin
      set_random_config();
      run_sessions(20);
    end
    set_random_config();
    no_idle = 1'b1;
    run_sessions(40);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_short_timers();
    test_late_first_check();
    test_zero_timeouts();
    test_threshold_extremes();
    test_random_settings();
    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_status.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_status.size()));
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
design/txprb_pkg.sv
design/wireless_power_tx_probe_fsm_unit.sv
design/txprb_checker.sv
dv/tb_top.sv
